FILE: rtl/core/wildcard_word_pattern_scanner_assert.svh
// Assertion macros for the pattern scanner.
`ifndef WILDCARD_WORD_PATTERN_SCANNER_ASSERT_SVH
`define WILDCARD_WORD_PATTERN_SCANNER_ASSERT_SVH

// Same-cycle implication.
`define WWPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WWPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/wwps_pkg.sv
package wwps_pkg;

   localparam int PATTERN_MAX = 64;
   localparam int INDEX_BITS  = 24;
   localparam int LEN_BITS    = 7;
   localparam int SLOT_BITS   = 6;
   localparam int WORD_BITS   = 32;
   localparam int ADDR_PAD    = WORD_BITS - INDEX_BITS - 2;

   localparam logic [WORD_BITS-1:0]  WILDCARD_MAX = 32'h0000_0010;
   localparam logic [WORD_BITS-1:0]  BASE_RESET   = 32'h8000_0000;
   localparam logic [LEN_BITS-1:0]   LEN_RESET    = 7'd1;
   localparam logic [INDEX_BITS-1:0] INDEX_LIMIT  = {INDEX_BITS{1'b1}};

   // Register select, taken from paddr[2]
   localparam logic REG_PATTERN_LENGTH = 1'b0;
   localparam logic REG_BASE_ADDRESS   = 1'b1;

   // Request kinds carried on tuser
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_SCAN = 1'b1;

   typedef struct packed {
      logic load_en;
      logic shift_en;
      logic clear;
   } cell_ctrl_type;

endpackage

FILE: rtl/core/wwps_cell.sv
module wwps_cell
   import wwps_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic                 load_sel,
   input  logic                 active,
   input  logic [WORD_BITS-1:0] word,
   input  logic                 prev_match,
   output logic                 match_bit,
   output logic                 partial
);

   logic [WORD_BITS-1:0] pat_ff, pat_in;
   logic                 wild_ff, wild_in;
   logic                 pm_ff, pm_in;

   // Pattern word and its wildcard flag are decided at load time
   always_comb begin
      pat_in  = pat_ff;
      wild_in = wild_ff;
      if (ctrl.load_en && load_sel) begin
         pat_in  = word;
         wild_in = (word <= WILDCARD_MAX);
      end
   end

   assign match_bit = prev_match && active && (wild_ff || (pat_ff == word));

   always_comb begin
      pm_in = pm_ff;
      if (ctrl.clear) begin
         pm_in = 1'b0;
      end else if (ctrl.shift_en) begin
         pm_in = match_bit;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff  <= pat_in;
      wild_ff <= wild_in;
      if (reset) begin
         pm_ff <= 1'b0;
      end else begin
         pm_ff <= pm_in;
      end
   end

   assign partial = pm_ff;

endmodule

FILE: rtl/core/wildcard_word_pattern_scanner.sv
// Response: a scan request that ends a match or a scan shows its response in the cycle after
// acceptance, from the response register. All pattern cells compare the word in parallel.
// Throughput: one request per cycle while the response register is free or draining.
// Reset: scan state, response valid and registers (length 1, base 0x80000000) are cleared;
// the pattern words are not reset and hold garbage until loaded.
`include "wildcard_word_pattern_scanner_assert.svh"

module wildcard_word_pattern_scanner
   import wwps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // slave side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [5:0] pattern_slot, [37:6] data_word, [39:38] zero
   input  logic        req_tuser,   // [0] mode
   input  logic        req_tlast,
   // master side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [23:0] match_index, [55:24] match_address
   output logic        rsp_tuser,   // [0] found
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [LEN_BITS-1:0]   len_ff, len_in;
   logic [WORD_BITS-1:0]  base_ff, base_in;
   logic [INDEX_BITS-1:0] seen_ff, seen_in;
   logic                  reported_ff, reported_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [INDEX_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic [WORD_BITS-1:0]  rsp_addr_ff, rsp_addr_in;

   logic                  csr_wr;
   logic                  accept, scan_acc, at_limit, hit, emit_found, emit;
   logic [SLOT_BITS-1:0]  slot;
   logic [WORD_BITS-1:0]  word;
   logic [LEN_BITS-1:0]   n_len;
   logic [INDEX_BITS-1:0] start;
   cell_ctrl_type         ctrl;
   logic [PATTERN_MAX-1:0] match_bits, pm_vec, tail_sel;

   assign slot = req_tdata[SLOT_BITS-1:0];
   assign word = req_tdata[SLOT_BITS+WORD_BITS-1:SLOT_BITS];

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      len_in  = len_ff;
      base_in = base_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_PATTERN_LENGTH: len_in  = csr_pwdata[LEN_BITS-1:0];
            REG_BASE_ADDRESS:   base_in = csr_pwdata;
            default:            len_in  = len_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_PATTERN_LENGTH: csr_prdata = {{(32-LEN_BITS){1'b0}}, len_ff};
         REG_BASE_ADDRESS:   csr_prdata = base_ff;
         default:            csr_prdata = '0;
      endcase
   end

   // Clamp length to 1..PATTERN_MAX
   always_comb begin
      if (len_ff == '0) begin
         n_len = LEN_BITS'(1);
      end else if (len_ff > LEN_BITS'(PATTERN_MAX)) begin
         n_len = LEN_BITS'(PATTERN_MAX);
      end else begin
         n_len = len_ff;
      end
   end

   // Handshake: accept while the response register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign scan_acc   = accept && (req_tuser == MODE_SCAN);
   assign at_limit   = (seen_ff == INDEX_LIMIT);

   assign ctrl.load_en  = accept && (req_tuser == MODE_LOAD);
   assign ctrl.shift_en = scan_acc && !at_limit && !req_tlast;
   assign ctrl.clear    = scan_acc && (at_limit || req_tlast);

   // Cell chain
   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      logic prev;
      if (i == 0) begin : g_head
         assign prev = 1'b1;
      end else begin : g_link
         assign prev = pm_vec[i-1];
      end
      assign tail_sel[i] = (n_len == LEN_BITS'(i + 1));

      wwps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .load_sel   (slot == SLOT_BITS'(i)),
         .active     (LEN_BITS'(i) < n_len),
         .word       (word),
         .prev_match (prev),
         .match_bit  (match_bits[i]),
         .partial    (pm_vec[i])
      );
   end

   assign hit        = |(match_bits & tail_sel);
   assign emit_found = scan_acc && !at_limit && hit && !reported_ff;
   assign emit       = emit_found || (scan_acc && req_tlast && !reported_ff);
   assign start      = seen_ff - INDEX_BITS'(n_len - LEN_BITS'(1));

   always_comb begin
      seen_in     = seen_ff;
      reported_in = reported_ff;
      if (scan_acc) begin
         if (req_tlast) begin
            seen_in     = '0;
            reported_in = 1'b0;
         end else begin
            if (!at_limit) begin
               seen_in = seen_ff + INDEX_BITS'(1);
            end
            if (emit_found) begin
               reported_in = 1'b1;
            end
         end
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      rsp_addr_in  = rsp_addr_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = emit_found;
         rsp_index_in = emit_found ? start : '0;
         rsp_addr_in  = emit_found ? (base_ff + {{ADDR_PAD{1'b0}}, start, 2'b00}) : '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_addr_ff  <= rsp_addr_in;
      if (reset) begin
         len_ff       <= LEN_RESET;
         base_ff      <= BASE_RESET;
         seen_ff      <= '0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         base_ff      <= base_in;
         seen_ff      <= seen_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {rsp_addr_ff, rsp_index_ff};

   `WWPS_ASSERT_NEXT(a_found_marks_reported, clock, reset,
      emit_found && !req_tlast, reported_ff, "found without marking the scan reported")
   `WWPS_ASSERT_NEXT(a_last_clears_scan, clock, reset,
      scan_acc && req_tlast, (seen_ff == '0) && (pm_vec == '0) && !reported_ff,
      "scan state not cleared after last word")
   `WWPS_ASSERT_NOW(a_not_found_is_zero, clock, reset,
      rsp_valid_ff && !rsp_found_ff, (rsp_index_ff == '0) && (rsp_addr_ff == '0),
      "not-found response carries nonzero payload")

endmodule
